[sv/ppc_pkg.sv]
// Shared widths and types for the polygon area / perimeter / center block.
// Used by ppc_mul, ppc_root, ppc_div and polygon_area_perimeter_center.
// No dependencies.
package ppc_pkg;

	// Vertex coordinates, signed Q12.12
	localparam int COORD_W = 24;
	// Vertices taken per polygon before the rest are dropped
	localparam int MAX_VERTICES = 64;
	// Vertex counter, wide enough to hold MAX_VERTICES itself
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	// Signed coordinate sums over up to MAX_VERTICES vertices
	localparam int SUM_W = COORD_W + $clog2(MAX_VERTICES) + 1;
	// Edge difference and product widths
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	// Squared edge length and its floor square root
	localparam int RAD_W = PROD_W;
	localparam int ROOT_W = RAD_W / 2;
	localparam int ROOT_REM_W = ROOT_W + 3;
	localparam int ROOT_ITER_W = $clog2(ROOT_W);
	localparam int DIV_ITER_W = $clog2(SUM_W);
	// Running shoelace sum and result widths
	localparam int CROSS_W = 56;
	localparam int AREA_W = 54;
	localparam int LEN_W = 32;
	localparam int CNT_OUT_W = 7;

	// Stream payload widths
	localparam int IN_DATA_W = 48;
	localparam int OUT_FIELDS_W = AREA_W + LEN_W + 2 * COORD_W + CNT_OUT_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [RAD_W-1:0] rad_t;
	typedef logic [ROOT_W-1:0] root_t;

endpackage

[sv/polygon_area_perimeter_center.sv]
// Polygon area, perimeter and vertex mean, one vertex per request.
// Depends on ppc_pkg, ppc_mul, ppc_root and ppc_div.
//
// Usage:
//   Send the vertices of one closed polygon in order on the s_ stream, x and
//   y in signed Q12.12, with s_tlast on the final vertex. One result request
//   leaves on the m_ stream for each polygon: area (24 fraction bits, half
//   the absolute shoelace sum), perimeter (Q20.12, saturating), center x/y
//   (mean, truncated toward zero), vertex count and, on m_tuser, a flag set
//   when more than MAX_VERTICES vertices came (the extras are dropped).
//   Flow: every vertex after the first that is taken runs one edge through
//   the shared multiplier (4 products) and the bit-serial square root
//   (ROOT_W = 25 steps). The last vertex adds the closing edge, two serial
//   divisions and the publish step into the output register. s_tready is
//   high only between vertices. Reset clears all running sums and the
//   output register; the block then accepts a first vertex at once.
//   Stall: a finished result waits in the output register while new vertices
//   are accepted; the next result holds back until the previous one is taken.
module polygon_area_perimeter_center (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// vertex_x [23:0], vertex_y [47:24]
	input  logic [ppc_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// area [53:0], perimeter [85:54], center_x [109:86], center_y [133:110],
	// vertex_count [140:134], zero [143:141]
	output logic [ppc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// too_many [0]
	output logic                             m_tuser
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_MUL,
		ST_ROOTGO,
		ST_ROOTW,
		ST_DIVXGO,
		ST_DIVXW,
		ST_DIVYGO,
		ST_DIVYW,
		ST_OUT
	} state_t;

	state_t                                state_q;
	logic [2:0]                            step_q;
	ppc_pkg::coord_t                       ax_q, ay_q, bx_q, by_q;
	ppc_pkg::coord_t                       first_x_q, first_y_q, prev_x_q, prev_y_q;
	ppc_pkg::prod_t                        cross_t_q;
	ppc_pkg::rad_t                         d2_q;
	logic signed [ppc_pkg::CROSS_W-1:0]    cross_sum_q;
	logic [ppc_pkg::LEN_W-1:0]             length_sum_q;
	ppc_pkg::sum_t                         x_sum_q, y_sum_q;
	ppc_pkg::count_t                       count_q;
	logic                                  overflowed_q;
	logic                                  last_q;
	logic                                  closing_q;
	ppc_pkg::coord_t                       cx_q;
	logic                                  out_valid_q;
	logic [ppc_pkg::OUT_DATA_W-1:0]        out_data_q;
	logic                                  out_user_q;

	ppc_pkg::coord_t                       in_x, in_y;
	logic                                  accept;
	logic                                  take;
	logic                                  out_free;
	ppc_pkg::diff_t                        dx, dy, mul_a, mul_b;
	ppc_pkg::prod_t                        mul_p;
	logic                                  root_start, root_done;
	ppc_pkg::root_t                        root;
	logic                                  div_start, div_done;
	ppc_pkg::sum_t                         div_num;
	ppc_pkg::coord_t                       div_q;
	logic signed [ppc_pkg::CROSS_W:0]      cross_add;
	logic signed [ppc_pkg::CROSS_W-1:0]    cross_next;
	logic [ppc_pkg::LEN_W:0]               len_add;
	logic [ppc_pkg::CROSS_W-1:0]           cross_mag;
	logic [ppc_pkg::CROSS_W-1:0]           half_mag;
	logic [ppc_pkg::AREA_W-1:0]            area;

	// Unpack the vertex request
	assign in_x     = ppc_pkg::coord_t'(s_tdata[ppc_pkg::COORD_W-1:0]);
	assign in_y     = ppc_pkg::coord_t'(s_tdata[2*ppc_pkg::COORD_W-1:ppc_pkg::COORD_W]);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign take     = count_q < ppc_pkg::CNT_W'(ppc_pkg::MAX_VERTICES);
	assign out_free = !out_valid_q || m_tready;

	// Select multiplier operands for the current edge step
	assign dx = ppc_pkg::diff_t'(ax_q) - ppc_pkg::diff_t'(bx_q);
	assign dy = ppc_pkg::diff_t'(ay_q) - ppc_pkg::diff_t'(by_q);

	always_comb begin
		case (step_q)
			3'd0: begin
				mul_a = ppc_pkg::diff_t'(ax_q);
				mul_b = ppc_pkg::diff_t'(by_q);
			end
			3'd1: begin
				mul_a = ppc_pkg::diff_t'(bx_q);
				mul_b = ppc_pkg::diff_t'(ay_q);
			end
			3'd2: begin
				mul_a = dx;
				mul_b = dx;
			end
			default: begin
				mul_a = dy;
				mul_b = dy;
			end
		endcase
	end

	ppc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	assign root_start = (state_q == ST_ROOTGO);

	ppc_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (d2_q),
		.done     (root_done),
		.root     (root)
	);

	assign div_start = (state_q == ST_DIVXGO) || (state_q == ST_DIVYGO);
	assign div_num   = (state_q == ST_DIVXGO) ? x_sum_q : y_sum_q;

	ppc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Saturating shoelace and perimeter accumulation
	assign cross_add = (ppc_pkg::CROSS_W+1)'(cross_sum_q) + (ppc_pkg::CROSS_W+1)'(cross_t_q);

	always_comb begin
		if (cross_add[ppc_pkg::CROSS_W] != cross_add[ppc_pkg::CROSS_W-1]) begin
			cross_next = cross_add[ppc_pkg::CROSS_W] ?
				{1'b1, {(ppc_pkg::CROSS_W-1){1'b0}}} : {1'b0, {(ppc_pkg::CROSS_W-1){1'b1}}};
		end else begin
			cross_next = cross_add[ppc_pkg::CROSS_W-1:0];
		end
	end

	assign len_add = (ppc_pkg::LEN_W+1)'(length_sum_q) + (ppc_pkg::LEN_W+1)'(root);

	// Area: half the magnitude, clamped to the field
	assign cross_mag = cross_sum_q[ppc_pkg::CROSS_W-1] ? -cross_sum_q : cross_sum_q;
	assign half_mag  = cross_mag >> 1;
	assign area      = (half_mag > ppc_pkg::CROSS_W'(ppc_pkg::AREA_MAX)) ?
		ppc_pkg::AREA_MAX : half_mag[ppc_pkg::AREA_W-1:0];

	// Sequencer, running sums and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			ax_q         <= '0;
			ay_q         <= '0;
			bx_q         <= '0;
			by_q         <= '0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			cross_t_q    <= '0;
			d2_q         <= '0;
			cross_sum_q  <= '0;
			length_sum_q <= '0;
			x_sum_q      <= '0;
			y_sum_q      <= '0;
			count_q      <= '0;
			overflowed_q <= 1'b0;
			last_q       <= 1'b0;
			closing_q    <= 1'b0;
			cx_q         <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_user_q   <= 1'b0;
		end else begin
			// Publish a finished result, drop it once taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q    <= s_tlast;
						closing_q <= 1'b0;
						step_q    <= '0;
						ax_q      <= prev_x_q;
						ay_q      <= prev_y_q;
						bx_q      <= in_x;
						by_q      <= in_y;
						if (take) begin
							if (count_q == '0) begin
								first_x_q <= in_x;
								first_y_q <= in_y;
							end
							prev_x_q <= in_x;
							prev_y_q <= in_y;
							x_sum_q  <= x_sum_q + ppc_pkg::SUM_W'(in_x);
							y_sum_q  <= y_sum_q + ppc_pkg::SUM_W'(in_y);
							count_q  <= count_q + 1'b1;
						end else begin
							overflowed_q <= 1'b1;
						end
						if (take && count_q != '0) begin
							state_q <= ST_MUL;
						end else if (s_tlast) begin
							state_q <= ST_CLOSE;
						end
					end
				end
				ST_CLOSE: begin
					// Closing edge: last accepted vertex back to the first
					ax_q      <= prev_x_q;
					ay_q      <= prev_y_q;
					bx_q      <= first_x_q;
					by_q      <= first_y_q;
					closing_q <= 1'b1;
					step_q    <= '0;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					case (step_q)
						3'd1: cross_t_q <= mul_p;
						3'd2: cross_t_q <= cross_t_q - mul_p;
						3'd3: d2_q <= ppc_pkg::RAD_W'(unsigned'(mul_p));
						3'd4: begin
							d2_q    <= d2_q + ppc_pkg::RAD_W'(unsigned'(mul_p));
							state_q <= ST_ROOTGO;
						end
						default: ;
					endcase
				end
				ST_ROOTGO: begin
					cross_sum_q <= cross_next;
					state_q     <= ST_ROOTW;
				end
				ST_ROOTW: begin
					if (root_done) begin
						length_sum_q <= len_add[ppc_pkg::LEN_W] ?
							ppc_pkg::LEN_MAX : len_add[ppc_pkg::LEN_W-1:0];
						if (closing_q) begin
							state_q <= ST_DIVXGO;
						end else if (last_q) begin
							state_q <= ST_CLOSE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIVXGO: begin
					state_q <= ST_DIVXW;
				end
				ST_DIVXW: begin
					if (div_done) begin
						cx_q    <= div_q;
						state_q <= ST_DIVYGO;
					end
				end
				ST_DIVYGO: begin
					state_q <= ST_DIVYW;
				end
				ST_DIVYW: begin
					// The divider holds the y mean until the result is published
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Hold until the previous result is gone, then publish and clear
					if (out_free) begin
						out_data_q <= {
							{(ppc_pkg::OUT_DATA_W-ppc_pkg::OUT_FIELDS_W){1'b0}},
							ppc_pkg::CNT_OUT_W'(count_q),
							div_q,
							cx_q,
							length_sum_q,
							area
						};
						out_user_q   <= overflowed_q;
						cross_sum_q  <= '0;
						length_sum_q <= '0;
						x_sum_q      <= '0;
						y_sum_q      <= '0;
						count_q      <= '0;
						overflowed_q <= 1'b0;
						first_x_q    <= '0;
						first_y_q    <= '0;
						prev_x_q     <= '0;
						prev_y_q     <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// The square root only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == ST_ROOTW)
		else $error("square root finished outside its wait state");

	// Accepted vertices never exceed the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ppc_pkg::CNT_W'(ppc_pkg::MAX_VERTICES))
		else $error("vertex count above limit");

	// A division never starts without a vertex
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> count_q != '0)
		else $error("division by zero vertices");

	// Publishing a result clears the running state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (count_q == '0 && m_tvalid))
		else $error("running state not cleared after result");

endmodule

[sv/ppc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on ppc_pkg for the operand and product types.
module ppc_mul (
	input  logic            clk,
	input  ppc_pkg::diff_t  a,
	input  ppc_pkg::diff_t  b,
	output ppc_pkg::prod_t  p_s1
);

	// Register the product; the result follows its operands in the next cycle
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

[sv/ppc_root.sv]
// Bit-serial floor square root: two radicand bits per cycle.
// Depends on ppc_pkg for widths.
module ppc_root (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ppc_pkg::rad_t  radicand,
	output logic           done,
	output ppc_pkg::root_t root
);

	ppc_pkg::rad_t                      rad_q;
	logic [ppc_pkg::ROOT_REM_W-1:0]     rem_q;
	ppc_pkg::root_t                     root_q;
	logic [ppc_pkg::ROOT_ITER_W-1:0]    iter_q;
	logic                               busy_q;
	logic                               done_q;
	logic [ppc_pkg::ROOT_REM_W-1:0]     rem_sh;
	logic [ppc_pkg::ROOT_REM_W-1:0]     trial;
	logic                               fits;

	// Bring down the next two radicand bits and try root*4 + 1
	assign rem_sh = {rem_q[ppc_pkg::ROOT_REM_W-3:0], rad_q[ppc_pkg::RAD_W-1 -: 2]};
	assign trial  = ppc_pkg::ROOT_REM_W'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	// Control: run ROOT_W steps after start, pulse done on the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ppc_pkg::ROOT_ITER_W'(ppc_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring square-root step
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ppc_pkg::ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[sv/ppc_div.sv]
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
// Depends on ppc_pkg for widths.
module ppc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ppc_pkg::sum_t    dividend,
	input  ppc_pkg::count_t  divisor,
	output logic             done,
	output ppc_pkg::coord_t  quotient
);

	logic [ppc_pkg::SUM_W-1:0]       num_q;
	logic [ppc_pkg::SUM_W-1:0]       quo_q;
	logic [ppc_pkg::CNT_W-1:0]       rem_q;
	ppc_pkg::count_t                 den_q;
	logic                            neg_q;
	logic [ppc_pkg::DIV_ITER_W-1:0]  iter_q;
	logic                            busy_q;
	logic                            done_q;
	logic [ppc_pkg::CNT_W:0]         rem_sh;
	logic [ppc_pkg::CNT_W:0]         rem_sub;
	logic                            fits;
	logic [ppc_pkg::SUM_W-1:0]       quo_signed;

	// Shift in the next dividend bit and try to subtract the divisor
	assign rem_sh  = {rem_q, num_q[ppc_pkg::SUM_W-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Control: SUM_W steps after start, pulse done on the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ppc_pkg::DIV_ITER_W'(ppc_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: divide magnitudes, keep the sign aside
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[ppc_pkg::SUM_W-1] ? -dividend : dividend;
			neg_q <= dividend[ppc_pkg::SUM_W-1];
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? rem_sub[ppc_pkg::CNT_W-1:0] : rem_sh[ppc_pkg::CNT_W-1:0];
			quo_q <= {quo_q[ppc_pkg::SUM_W-2:0], fits};
		end
	end

	// Restore the sign; the mean always fits a coordinate
	assign quo_signed = neg_q ? -quo_q : quo_q;
	assign quotient   = ppc_pkg::coord_t'(quo_signed[ppc_pkg::COORD_W-1:0]);
	assign done       = done_q;

endmodule

[sim/polygon_checker.sv]
`timescale 1ns / 1ps
// Result checker for polygon_area_perimeter_center: watches both streams, predicts
// area, perimeter, center, count and drop flag per polygon, and compares in order.
// Depends on ppc_pkg for widths and the coordinate type.
module polygon_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ppc_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [ppc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tuser,
	output int                             fail_count,
	output int                             pending
);
	import ppc_pkg::*;

	localparam int PERIM_LO = AREA_W;
	localparam int CX_LO = PERIM_LO + LEN_W;
	localparam int CY_LO = CX_LO + COORD_W;
	localparam int CNT_LO = CY_LO + COORD_W;
	localparam longint CROSS_MAX = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint CROSS_MIN = -CROSS_MAX - 1;

	typedef struct {
		logic [AREA_W-1:0]    area;
		logic [LEN_W-1:0]     perimeter;
		coord_t               center_x;
		coord_t               center_y;
		logic [CNT_OUT_W-1:0] vertex_count;
		logic                 too_many;
	} polygon_result_t;

	polygon_result_t expected_polygons[$];

	// running state of the polygon being collected
	longint first_x, first_y, prev_x, prev_y;
	longint cross_sum, x_sum, y_sum;
	logic [LEN_W-1:0] length_sum;
	int vertices_taken;
	logic dropped;

	task automatic clear_polygon();
		first_x = 0;
		first_y = 0;
		prev_x = 0;
		prev_y = 0;
		cross_sum = 0;
		x_sum = 0;
		y_sum = 0;
		length_sum = '0;
		vertices_taken = 0;
		dropped = 1'b0;
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// floor square root, one result bit per pass
	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned rest, root, probe;
		rest = n;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > rest)
			probe >>= 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// accumulate one edge a->b into the shoelace and length sums, both saturating
	task automatic add_edge(longint ax, longint ay, longint bx, longint by);
		longint cross_acc, dx, dy;
		longint unsigned len;
		cross_acc = cross_sum + (ax * by - bx * ay);
		dx = ax - bx;
		dy = ay - by;
		len = longint'(length_sum) + floor_root(dx * dx + dy * dy);
		if (cross_acc > CROSS_MAX)
			cross_acc = CROSS_MAX;
		if (cross_acc < CROSS_MIN)
			cross_acc = CROSS_MIN;
		cross_sum = cross_acc;
		length_sum = (len > 64'h0000_0000_FFFF_FFFF) ? LEN_MAX : len[LEN_W-1:0];
	endtask

	// fold one accepted vertex in; on the closing vertex, queue the expected result
	task automatic fold_vertex(coord_t x, coord_t y, logic closing);
		longint xs, ys, cx, cy;
		longint unsigned mag;
		polygon_result_t res;
		xs = x;
		ys = y;
		cx = 0;
		cy = 0;
		if (vertices_taken < MAX_VERTICES) begin
			if (vertices_taken == 0) begin
				first_x = xs;
				first_y = ys;
			end else begin
				add_edge(prev_x, prev_y, xs, ys);
			end
			prev_x = xs;
			prev_y = ys;
			x_sum += xs;
			y_sum += ys;
			vertices_taken++;
		end else begin
			dropped = 1'b1;
		end
		if (closing) begin
			if (vertices_taken > 0) begin
				add_edge(prev_x, prev_y, first_x, first_y);
				cx = x_sum / longint'(vertices_taken);
				cy = y_sum / longint'(vertices_taken);
			end
			mag = (cross_sum < 0) ? -cross_sum : cross_sum;
			mag >>= 1;
			if (mag > AREA_MAX)
				mag = AREA_MAX;
			res.area = mag[AREA_W-1:0];
			res.perimeter = length_sum;
			res.center_x = cx[COORD_W-1:0];
			res.center_y = cy[COORD_W-1:0];
			res.vertex_count = vertices_taken[CNT_OUT_W-1:0];
			res.too_many = dropped;
			expected_polygons = {expected_polygons, res};
			clear_polygon();
		end
	endtask

	// check results first, so a result never meets an expectation queued on the same edge
	always @(posedge clk) begin
		polygon_result_t want;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
			expected_polygons.delete();
			clear_polygon();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_polygons.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata[63:0], '0);
				end else begin
					want = expected_polygons.pop_front();
					if (m_tdata[PERIM_LO-1:0] !== want.area)
						report_mismatch("area", m_tdata[PERIM_LO-1:0], want.area);
					if (m_tdata[PERIM_LO +: LEN_W] !== want.perimeter)
						report_mismatch("perimeter", m_tdata[PERIM_LO +: LEN_W], want.perimeter);
					if (m_tdata[CX_LO +: COORD_W] !== want.center_x)
						report_mismatch("center_x", m_tdata[CX_LO +: COORD_W], want.center_x);
					if (m_tdata[CY_LO +: COORD_W] !== want.center_y)
						report_mismatch("center_y", m_tdata[CY_LO +: COORD_W], want.center_y);
					if (m_tdata[CNT_LO +: CNT_OUT_W] !== want.vertex_count)
						report_mismatch("vertex_count", m_tdata[CNT_LO +: CNT_OUT_W],
							want.vertex_count);
					if (m_tuser !== want.too_many)
						report_mismatch("too_many", m_tuser, want.too_many);
				end
			end
			if (s_tvalid && s_tready)
				fold_vertex(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W], s_tlast);
			pending = expected_polygons.size();
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the polygon_area_perimeter_center test: clock, reset, vertex stimulus and
// the verdict. Depends on ppc_pkg, the block and polygon_checker.
module testbench;
	import ppc_pkg::*;

	typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} spread_t;

	localparam coord_t COORD_MAX = 24'h7FFFFF;
	localparam coord_t COORD_MIN = 24'h800000;
	localparam coord_t ONE = 24'h001000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	int                    fail_count;
	int                    pending;
	int                    send_idle;
	int                    recv_idle;
	int                    vertices_sent;

	polygon_area_perimeter_center uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	polygon_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// stop a hung run
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: stall at random on each falling edge
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic coord_t pick_coord(spread_t spread);
		int near;
		case (spread)
			SPREAD_FULL: return coord_t'($urandom);
			SPREAD_NEAR: begin
				near = $urandom_range(131071);
				return coord_t'(near - 65536);
			end
			default: begin
				case ($urandom_range(4))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					3: return '1;
					default: return 24'sd1;
				endcase
			end
		endcase
	endfunction

	// offer one vertex after a random gap, hold it until taken; enter and leave on a falling edge
	task automatic send_vertex(coord_t x, coord_t y, logic closing);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			s_tdata = IN_DATA_W'({$urandom, $urandom});
			s_tlast = 1'($urandom_range(1));
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {y, x};
		s_tlast = closing;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		vertices_sent++;
	endtask

	task automatic send_polygon(int n);
		for (int i = 0; i < n; i++)
			send_vertex(pick_coord(spread_t'($urandom_range(2))),
				pick_coord(spread_t'($urandom_range(2))), i == n - 1);
	endtask

	task automatic random_phase(int target, int sender_pct, int receiver_pct);
		int n;
		int pick;
		send_idle = sender_pct;
		recv_idle = receiver_pct;
		// open each phase with a polygon that runs past the vertex limit
		send_polygon(MAX_VERTICES + 1 + $urandom_range(4));
		while (vertices_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 5)
				n = $urandom_range(MAX_VERTICES + 6, MAX_VERTICES - 4);
			else if (pick < 15)
				n = $urandom_range(2, 1);
			else
				n = $urandom_range(12, 3);
			send_polygon(n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		send_idle = 37;
		recv_idle = 79;
		vertices_sent = 0;
		repeat (11)
			@(negedge clk);
		arst_n = 1'b1;

		// single vertices at opposite corners
		send_vertex(COORD_MAX, COORD_MIN, 1'b1);
		send_vertex(COORD_MIN, COORD_MAX, 1'b1);
		// two-vertex polygon along the long diagonal
		send_vertex('0, '0, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b1);
		// widest triangle, both windings
		send_vertex(COORD_MIN, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b1);
		send_vertex(COORD_MIN, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, 1'b1);
		// unit square
		send_vertex('0, '0, 1'b0);
		send_vertex(ONE, '0, 1'b0);
		send_vertex(ONE, ONE, 1'b0);
		send_vertex('0, ONE, 1'b1);
		// repeated point, then a flat line
		send_vertex('1, '1, 1'b0);
		send_vertex('1, '1, 1'b0);
		send_vertex('1, '1, 1'b1);
		send_vertex(COORD_MIN, '0, 1'b0);
		send_vertex('0, '0, 1'b0);
		send_vertex(COORD_MAX, '0, 1'b1);
		// negative means that truncate toward zero
		send_vertex(-24'sd3, -24'sd5, 1'b0);
		send_vertex(-24'sd4, -24'sd6, 1'b1);

		random_phase(vertices_sent + 170, 37, 79);
		random_phase(vertices_sent + 170, 79, 37);
		random_phase(vertices_sent + 170, 0, 0);
		s_tvalid = 1'b0;

		// drain the last results, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (200)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
sv/ppc_pkg.sv
sv/ppc_mul.sv
sv/ppc_root.sv
sv/ppc_div.sv
sv/polygon_area_perimeter_center.sv
sim/polygon_checker.sv
sim/testbench.sv
